// ===== src/dtt_pkg.sv =====
`default_nettype none

package dtt_pkg;

	localparam int DTT_ENTRIES    = 4;
	localparam int DTT_DESC_WIDTH = 8;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_LOOKUP = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	// Pipeline control seen by the table: a request sits in the input register
	// and the result register can take it this cycle.
	typedef struct packed {
		logic valid_s1;
		logic advance;
	} pipe_ctl_t;

	// Single-bit result flags handed from the table to the result register.
	typedef struct packed {
		logic device_flag;
		logic table_full;
	} res_flags_t;

endpackage

`default_nettype wire

// ===== src/descriptor_translation_table.sv =====
// Descriptor translation table: maps small local descriptor numbers to host
// descriptors, each carrying a device flag.
// Input channel (in_valid/in_ready) carries one request item: kind selects
// insert, lookup, remove or clear all. Output channel (out_valid/out_ready)
// returns exactly one result item per request, in request order.
// An accepted item waits in the request register and moves into the output
// register when the result register can take it. Throughput: one item per
// cycle while the receiver does not stall, since the whole table is compared
// in parallel between the two registers and is updated as the request advances.
// When the receiver stalls, the result register holds its item, the request
// register holds the next one, and in_ready falls once both are occupied;
// nothing is lost or repeated. Table updates wait with their request.
// Reset (arst_n low) empties both pipeline registers and clears every valid
// bit; the stored numbers and host descriptors are left as they are, since an
// invalid entry is never read. Remove and clear results carry zeros.
`default_nettype none

module descriptor_translation_table import dtt_pkg::*; #(
	parameter int ENTRIES    = DTT_ENTRIES,
	parameter int DESC_WIDTH = DTT_DESC_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            kind,
	input  wire logic [DESC_WIDTH-1:0] host_desc,
	input  wire logic                  device_flag_in,
	input  wire logic [DESC_WIDTH-1:0] local_desc,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [DESC_WIDTH-1:0]      result_desc,
	output logic                       device_flag_out,
	output logic                       table_full
);

	logic                  valid_s1;
	kind_t                 kind_s1;
	logic [DESC_WIDTH-1:0] host_s1;
	logic                  dev_s1;
	logic [DESC_WIDTH-1:0] local_s1;
	logic                  advance;
	pipe_ctl_t             ctl;
	logic [DESC_WIDTH-1:0] res_desc;
	res_flags_t            res_flags;
	logic [ENTRIES-1:0]    valid_vec;

	assign ctl.valid_s1 = valid_s1;
	assign ctl.advance  = advance;

	// Request register: one item waiting for the table.
	dtt_req_reg #(
		.DESC_WIDTH(DESC_WIDTH)
	) u_req (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.host_desc(host_desc),
		.device_flag_in(device_flag_in),
		.local_desc(local_desc),
		.advance(advance),
		.valid_s1(valid_s1),
		.kind_s1(kind_s1),
		.host_s1(host_s1),
		.dev_s1(dev_s1),
		.local_s1(local_s1)
	);

	// Table storage with its parallel compare, allocation and result logic.
	dtt_table #(
		.ENTRIES(ENTRIES),
		.DESC_WIDTH(DESC_WIDTH)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.kind_s1(kind_s1),
		.host_s1(host_s1),
		.dev_s1(dev_s1),
		.local_s1(local_s1),
		.res_desc(res_desc),
		.res_flags(res_flags),
		.valid_vec(valid_vec)
	);

	// Result register: holds the finished item until the receiver takes it.
	dtt_res_reg #(
		.DESC_WIDTH(DESC_WIDTH)
	) u_res (
		.clk(clk),
		.arst_n(arst_n),
		.valid_s1(valid_s1),
		.res_desc(res_desc),
		.res_flags(res_flags),
		.advance(advance),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_desc(result_desc),
		.device_flag_out(device_flag_out),
		.table_full(table_full)
	);

`ifndef ASSERT_OFF
	// A full-table result always reads all ones and never carries a device flag.
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> result_desc == '1 && !device_flag_out)
		else $error("full result not all ones");

	// A clear leaves no valid entry behind.
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && kind_s1 == KIND_CLEAR |=> valid_vec == '0)
		else $error("clear left valid entries");

	// A successful insert adds exactly one valid entry.
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && kind_s1 == KIND_INSERT && !res_flags.table_full
		|=> $countones(valid_vec) == $countones($past(valid_vec)) + 1)
		else $error("insert did not add one entry");

	// A request waiting behind a stalled result is not dropped.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("request lost during stall");
`endif

endmodule

`default_nettype wire

// ===== src/dtt_req_reg.sv =====
`default_nettype none

module dtt_req_reg import dtt_pkg::*; #(
	parameter int DESC_WIDTH = DTT_DESC_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            kind,
	input  wire logic [DESC_WIDTH-1:0] host_desc,
	input  wire logic                  device_flag_in,
	input  wire logic [DESC_WIDTH-1:0] local_desc,
	input  wire logic                  advance,
	output logic                       valid_s1,
	output kind_t                      kind_s1,
	output logic [DESC_WIDTH-1:0]      host_s1,
	output logic                       dev_s1,
	output logic [DESC_WIDTH-1:0]      local_s1
);

	// The register empties whenever its item moves on, so it refills in the same cycle.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1  <= kind_t'(kind);
			host_s1  <= host_desc;
			dev_s1   <= device_flag_in;
			local_s1 <= local_desc;
		end
	end

endmodule

`default_nettype wire

// ===== src/dtt_table.sv =====
`default_nettype none

module dtt_table import dtt_pkg::*; #(
	parameter int ENTRIES    = DTT_ENTRIES,
	parameter int DESC_WIDTH = DTT_DESC_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pipe_ctl_t             ctl,
	input  wire kind_t                 kind_s1,
	input  wire logic [DESC_WIDTH-1:0] host_s1,
	input  wire logic                  dev_s1,
	input  wire logic [DESC_WIDTH-1:0] local_s1,
	output logic [DESC_WIDTH-1:0]      res_desc,
	output res_flags_t                 res_flags,
	output logic [ENTRIES-1:0]         valid_vec
);

	localparam int IW = $clog2(ENTRIES);

	logic [IW-1:0]         local_q  [ENTRIES];
	logic [DESC_WIDTH-1:0] host_q   [ENTRIES];
	logic                  dev_q    [ENTRIES];
	logic [ENTRIES-1:0]    valid_q;

	logic                  fire;
	logic [ENTRIES-1:0]    num_used;
	logic [ENTRIES-1:0]    local_hit;
	logic                  have_num;
	logic [IW-1:0]         free_num;
	logic                  have_slot;
	logic [IW-1:0]         free_slot;
	logic                  do_insert;

	assign fire      = ctl.valid_s1 && ctl.advance;
	assign valid_vec = valid_q;

	always_comb begin
		num_used  = '0;
		local_hit = '0;
		have_num  = 1'b0;
		free_num  = '0;
		have_slot = 1'b0;
		free_slot = '0;
		for (int c = 0; c < ENTRIES; c++) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (valid_q[i] && local_q[i] == IW'(c)) begin
					num_used[c] = 1'b1;
				end
			end
		end
		// Walk downwards so that the lowest free number and slot win.
		for (int c = ENTRIES - 1; c >= 0; c--) begin
			if (!num_used[c]) begin
				have_num = 1'b1;
				free_num = IW'(c);
			end
			if (!valid_q[c]) begin
				have_slot = 1'b1;
				free_slot = IW'(c);
			end
		end
		for (int i = 0; i < ENTRIES; i++) begin
			local_hit[i] = (local_s1 == DESC_WIDTH'(local_q[i]));
		end
	end

	assign do_insert = fire && kind_s1 == KIND_INSERT && have_num && have_slot;

	always_comb begin
		res_desc  = '0;
		res_flags = '0;
		unique case (kind_s1)
			KIND_INSERT: begin
				if (have_num && have_slot) begin
					res_desc = DESC_WIDTH'(free_num);
				end else begin
					res_desc             = '1;
					res_flags.table_full = 1'b1;
				end
			end
			KIND_LOOKUP: begin
				res_desc = local_s1;
				// Ascending order: the highest-indexed valid match takes the result.
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i] && local_hit[i]) begin
						res_desc              = host_q[i];
						res_flags.device_flag = dev_q[i];
					end
				end
			end
			KIND_REMOVE, KIND_CLEAR: begin
				res_desc = '0;
			end
			default: begin
				res_desc = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (fire) begin
			unique case (kind_s1)
				KIND_INSERT: begin
					if (do_insert) begin
						valid_q[free_slot] <= 1'b1;
					end
				end
				KIND_REMOVE: begin
					valid_q <= valid_q & ~local_hit;
				end
				KIND_CLEAR: begin
					valid_q <= '0;
				end
				default: begin
					valid_q <= valid_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_insert) begin
			local_q[free_slot] <= free_num;
			host_q[free_slot]  <= host_s1;
			dev_q[free_slot]   <= dev_s1;
		end
	end

endmodule

`default_nettype wire

// ===== src/dtt_res_reg.sv =====
`default_nettype none

module dtt_res_reg import dtt_pkg::*; #(
	parameter int DESC_WIDTH = DTT_DESC_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  valid_s1,
	input  wire logic [DESC_WIDTH-1:0] res_desc,
	input  wire res_flags_t            res_flags,
	output logic                       advance,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [DESC_WIDTH-1:0]      result_desc,
	output logic                       device_flag_out,
	output logic                       table_full
);

	assign advance = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_desc     <= res_desc;
			device_flag_out <= res_flags.device_flag;
			table_full      <= res_flags.table_full;
		end
	end

endmodule

`default_nettype wire
